FILE: hdl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared widths, codes and defaults for the indexed set swap-remove unit.
// ----------------------------------------------------------------------------
package iss_pkg;

  // Field widths of the stream words
  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int PICK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 7;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = ACTION_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1 + STATUS_W;

  // Default store depth
  localparam int CAPACITY_DEF = 64;

  // Operation codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PICK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

endpackage

FILE: hdl/iss_cam.sv
// ----------------------------------------------------------------------------
// iss_cam
// Row of value cells with a match comparator per cell. Only cells below the
// occupancy count take part in the lookup; the hit slot is encoded to binary.
// ----------------------------------------------------------------------------
module iss_cam import iss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CW-1:0]      count_i,
  input  logic [VALUE_W-1:0] key_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [VALUE_W-1:0] wr_data_i,
  output logic               hit_o,
  output logic [AW-1:0]      slot_o
);

  logic [VALUE_W-1:0]  cells_q [CAPACITY];
  logic [CAPACITY-1:0] match;

  // Cell writes: one slot per cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (wr_en_i && (wr_addr_i == AW'(i))) begin
        cells_q[i] <= wr_data_i;
      end
    end
  end

  // Per-cell compare, masked by occupancy
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_i) && (cells_q[i] == key_i);
    end
  end

  // Values are distinct, so at most one bit is set: OR-encode it
  always_comb begin
    slot_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        slot_o = slot_o | AW'(i);
      end
    end
  end

  assign hit_o = |match;

  // Stored values stay distinct
  a_match_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("iss_cam: more than one cell matches the key");

endmodule

FILE: hdl/iss_ram.sv
// ----------------------------------------------------------------------------
// iss_ram
// Shadow copy of the value store for indexed reads. One write port and two
// registered read ports; a read at the address written in the same cycle
// returns the new data.
// ----------------------------------------------------------------------------
module iss_ram import iss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 6
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [VALUE_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_a_addr_i,
  input  logic [AW-1:0]      rd_b_addr_i,
  output logic [VALUE_W-1:0] rd_a_data_o,
  output logic [VALUE_W-1:0] rd_b_data_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_a_q;
  logic [VALUE_W-1:0] rd_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports, write-first on an address collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_a_addr_i)) begin
        rd_a_q <= wr_data_i;
      end else begin
        rd_a_q <= mem[rd_a_addr_i];
      end
      if (wr_en_i && (wr_addr_i == rd_b_addr_i)) begin
        rd_b_q <= wr_data_i;
      end else begin
        rd_b_q <= mem[rd_b_addr_i];
      end
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

FILE: hdl/indexed_set_swap_remove_unit.sv
// ----------------------------------------------------------------------------
// indexed_set_swap_remove_unit
// Set of distinct 32-bit values, densely packed, with insert, swap-remove
// and pick-by-index.
// ----------------------------------------------------------------------------
// One word is accepted per clock unless the result side stalls. Its result word
// goes through the input register, then the result register, and waits there
// until taken, so the unit sustains one operation per cycle without stalls. The
// rate rests on the combinational lookup: a comparator per cell matches the
// value against all occupied entries while the swap source and the pick entry
// come from a shadow RAM read issued when the word is accepted; the store write
// and count update commit in the same cycle as the lookup. The store holds
// CAPACITY values and is not cleared at reset; only count and valid flags are.
// ----------------------------------------------------------------------------
module indexed_set_swap_remove_unit import iss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] item_value, [37:32] pick_index
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] action
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] picked_value, [38:32] occupancy
  output logic [OUT_USER_W-1:0] m_axis_tuser   // [0] accepted, [3:1] status
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PICK_W) ? CW : PICK_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Input register
  logic                in_vld_q;
  logic [ACTION_W-1:0] act_q;
  logic [VALUE_W-1:0]  val_q;
  logic [PICK_W-1:0]   idx_q;

  // Result register
  logic                out_vld_q;
  logic                ok_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  picked_q;
  logic [OCC_W-1:0]    occ_q;

  // Occupancy
  logic [CW-1:0] cnt_q, cnt_d, cnt_next;

  // Handshake
  logic fire, load;

  // Lookup and store access
  logic               hit;
  logic [AW-1:0]      slot;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [AW-1:0]      rd_pick_addr, rd_last_addr;
  logic [VALUE_W-1:0] rd_pick_data, rd_last_data;

  // Decision
  logic                ok;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  picked;
  logic                upd;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign load          = s_axis_tvalid && s_axis_tready;

  iss_cam #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_cam (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .count_i   (cnt_q),
    .key_i     (val_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .hit_o     (hit),
    .slot_o    (slot)
  );

  iss_ram #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (load),
    .rd_a_addr_i (rd_pick_addr),
    .rd_b_addr_i (rd_last_addr),
    .rd_a_data_o (rd_pick_data),
    .rd_b_data_o (rd_last_data)
  );

  // Operation decode for the word in the input register
  always_comb begin
    ok       = 1'b0;
    status   = ST_RANGE;
    picked   = '0;
    upd      = 1'b0;
    cnt_next = cnt_q;
    wr_addr  = slot;
    wr_data  = rd_last_data;
    case (act_q)
      ACT_INSERT: begin
        if (hit) begin
          status = ST_PRESENT;
        end else if (cnt_q >= CAP_C) begin
          status = ST_FULL;
        end else begin
          ok       = 1'b1;
          status   = ST_OK;
          upd      = 1'b1;
          wr_addr  = cnt_q[AW-1:0];
          wr_data  = val_q;
          cnt_next = cnt_q + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          // move the last entry into the freed slot
          ok       = 1'b1;
          status   = ST_OK;
          upd      = 1'b1;
          cnt_next = cnt_q - CW'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      ACT_PICK: begin
        if (CMPW'(idx_q) < CMPW'(cnt_q)) begin
          ok     = 1'b1;
          status = ST_OK;
          picked = rd_pick_data;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign wr_en = fire && upd;
  assign cnt_d = fire ? cnt_next : cnt_q;

  // Reads for the incoming word see the count left by the word in flight
  assign rd_pick_addr = AW'(s_axis_tdata[VALUE_W +: PICK_W]);
  assign rd_last_addr = AW'(cnt_d - CW'(1));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (load) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q <= s_axis_tuser[ACTION_W-1:0];
      val_q <= s_axis_tdata[VALUE_W-1:0];
      idx_q <= s_axis_tdata[VALUE_W +: PICK_W];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ok_q     <= ok;
      status_q <= status;
      picked_q <= picked;
      occ_q    <= OCC_W'(cnt_next);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - OCC_W){1'b0}}, occ_q, picked_q};
  assign m_axis_tuser  = {status_q, ok_q};

  // Count stays within the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("iss: occupancy beyond capacity");

  // Store is written only when a word commits
  a_wr_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> fire)
    else $error("iss: store write without commit");

  // Count moves only on a committed insert or remove
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(cnt_q))
    else $error("iss: occupancy changed without a store write");

  // Successful insert grows the count by one
  a_ins_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (act_q == ACT_INSERT)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("iss: insert did not grow occupancy");

  // Accepted flag agrees with the status code
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (ok_q == (status_q == ST_OK)))
    else $error("iss: accepted flag disagrees with status");

endmodule

FILE: test/indexed_set_swap_remove_unit_tb.sv
// ----------------------------------------------------------------------------
// indexed_set_swap_remove_unit_tb
// Self-checking bench for the indexed set unit. A queue of request words,
// first directed corner cases and then random fill, drain and mixed phases,
// feeds a stream driver. A set predictor updates on every accepted request.
// The monitor compares each result word field by field with the oldest
// prediction. Both stream sides idle at random, and the result side holds
// off once for a long stretch so that the unit backs up onto its input.
// ----------------------------------------------------------------------------
module indexed_set_swap_remove_unit_tb;
  import iss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 31;
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1100;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 250;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE    = 80;
  localparam int BLOCKS       = 15;
  localparam int BLOCK_LEN    = 120;

  // Unused action code: no change, out-of-range status
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic [PICK_W-1:0]         index;
  } set_request_t;

  typedef struct packed {
    logic                      accepted;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] picked;
    logic [OCC_W-1:0]          occupancy;
  } set_result_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] item_value, [37:32] pick_index
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // [1:0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [31:0] picked_value, [38:32] occupancy
  logic [OUT_USER_W-1:0] m_axis_tuser;        // [0] accepted, [3:1] status

  // Requests waiting to be sent, and results predicted but not yet seen
  set_request_t request_q[$];
  set_result_t  result_q[$];

  // Predictor copy of the set
  logic signed [VALUE_W-1:0] member_mem [CAPACITY_DEF];
  int                        member_count = 0;

  int error_count  = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int hold_left    = 0;
  logic hold_done  = 1'b0;

  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

  indexed_set_swap_remove_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Apply one request to the predicted set and return the expected word
  function automatic set_result_t apply_set_op(set_request_t req);
    set_result_t res;
    logic        hit;
    int          slot;
    res = '{accepted: 1'b0, status: ST_RANGE, picked: '0, occupancy: '0};
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < member_count; i++) begin
      if (!hit && member_mem[i] == req.value) begin
        hit = 1'b1;
        slot = i;
      end
    end
    case (req.action)
      ACT_INSERT: begin
        if (hit) begin
          res.status = ST_PRESENT;
        end else if (member_count >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          member_mem[member_count] = req.value;
          member_count++;
          res.accepted = 1'b1;
          res.status = ST_OK;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          // swap the last entry into the freed slot
          member_mem[slot] = member_mem[member_count-1];
          member_count--;
          res.accepted = 1'b1;
          res.status = ST_OK;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      ACT_PICK: begin
        if (int'(req.index) < member_count) begin
          res.picked = member_mem[req.index];
          res.accepted = 1'b1;
          res.status = ST_OK;
        end
      end
      default: ;  // unused code: no change, out-of-range status
    endcase
    res.occupancy = member_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic void push_request(logic [ACTION_W-1:0] act,
                                       logic signed [VALUE_W-1:0] val,
                                       logic [PICK_W-1:0] idx);
    set_request_t req;
    req = '{action: act, value: val, index: idx};
    request_q = {request_q, req};
  endfunction

  function automatic logic signed [VALUE_W-1:0] pool_value();
    // mostly pool values so inserts collide and removes hit
    if ($urandom_range(99) < 5) return $urandom;
    return value_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] exp_val,
                             logic [VALUE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
               exp_val, act_val);
      error_count++;
    end
  endtask

  // Request driver: next word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q = {result_q, apply_set_op('{action: s_axis_tuser,
                                             value:  s_axis_tdata[31:0],
                                             index:  s_axis_tdata[37:32]})};
        words_sent <= words_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 &&
            ((words_sent >= QUIET_FROM && words_sent < QUIET_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          set_request_t req;
          req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, req.index, req.value};
          s_axis_tuser  <= req.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= (words_sent >= QUIET_FROM && words_sent < QUIET_TO) ||
                       ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    set_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h_%0h",
                 $realtime, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        exp_res = result_q.pop_front();
        check_field("accepted", exp_res.accepted, m_axis_tuser[0]);
        check_field("status", exp_res.status, m_axis_tuser[3:1]);
        check_field("picked_value", exp_res.picked, m_axis_tdata[31:0]);
        check_field("occupancy", exp_res.occupancy, m_axis_tdata[38:32]);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    phase_e phase;
    int     pick_roll;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = 32'shffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // Directed: empty set, extremes, duplicate, pick bounds, swap and last removal
    push_request(ACT_PICK,   32'sh0000_0000, 6'd0);
    push_request(ACT_REMOVE, 32'sh0000_0005, 6'd0);
    push_request(ACT_NONE,   32'sh1234_5678, 6'd9);
    push_request(ACT_INSERT, 32'sh8000_0000, 6'd63);
    push_request(ACT_INSERT, 32'sh7fff_ffff, 6'd0);
    push_request(ACT_INSERT, 32'sh0000_0000, 6'd0);
    push_request(ACT_INSERT, 32'shffff_ffff, 6'd0);
    push_request(ACT_INSERT, 32'sh7fff_ffff, 6'd0);
    push_request(ACT_INSERT, 32'sh5555_5555, 6'd0);
    push_request(ACT_INSERT, 32'shaaaa_aaaa, 6'd0);
    push_request(ACT_PICK,   32'shffff_ffff, 6'd0);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd5);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd6);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd63);
    push_request(ACT_NONE,   32'shffff_ffff, 6'd1);
    push_request(ACT_REMOVE, 32'sh8000_0000, 6'd0);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd0);
    push_request(ACT_REMOVE, 32'sh5555_5555, 6'd0);
    push_request(ACT_REMOVE, 32'sh1234_5678, 6'd0);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd2);
    push_request(ACT_PICK,   32'sh0000_0000, 6'd3);

    // Random: alternate fill, drain and mixed phases over the value pool
    for (int b = 0; b < BLOCKS; b++) begin
      phase = phase_e'(b % 3);
      for (int n = 0; n < BLOCK_LEN; n++) begin
        pick_roll = $urandom_range(99);
        if (pick_roll < 3) begin
          push_request(ACT_NONE, $urandom, $urandom_range(63));
        end else if (pick_roll < 15) begin
          push_request(ACT_PICK, $urandom, $urandom_range(63));
        end else if ((phase == PH_FILL  && pick_roll < 88) ||
                     (phase == PH_DRAIN && pick_roll < 25) ||
                     (phase == PH_MIXED && pick_roll < 57)) begin
          push_request(ACT_INSERT, pool_value(), $urandom_range(63));
        end else begin
          push_request(ACT_REMOVE, pool_value(), $urandom_range(63));
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
